// ----- design/mrc_pkg.sv -----
// mrc_pkg: widths, types, state encoding and control structs for the merged
// region centroid block. no dependencies.

package mrc_pkg;

  localparam int COORD_BITS  = 10;
  localparam int WEIGHT_BITS = 32;

  localparam int SUM_IN_W    = 42;
  localparam int WEIGHT_IN_W = 32;
  localparam int TOTAL_SUM_W = 50;
  localparam int TOTAL_W_W   = 40;
  localparam int COORD_OUT_W = 10;

  localparam int DIV_W = (TOTAL_SUM_W > TOTAL_W_W + COORD_BITS) ?
                         TOTAL_SUM_W : TOTAL_W_W + COORD_BITS;
  localparam int CNT_W = $clog2(COORD_BITS + 1);

  typedef logic [SUM_IN_W-1:0]    sum_in_t;
  typedef logic [WEIGHT_IN_W-1:0] weight_in_t;
  typedef logic [TOTAL_SUM_W-1:0] total_sum_t;
  typedef logic [TOTAL_W_W-1:0]   total_w_t;
  typedef logic [TOTAL_SUM_W:0]   sum_ext_t;
  typedef logic [TOTAL_W_W:0]     w_ext_t;
  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [COORD_OUT_W-1:0] coord_out_t;
  typedef logic [DIV_W-1:0]       div_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam total_sum_t TOTAL_SUM_MAX  = '1;
  localparam total_w_t   TOTAL_W_MAX    = '1;
  localparam total_w_t   WEIGHT_IN_MASK = total_w_t'({WEIGHT_BITS{1'b1}});
  localparam cnt_t       LAST_STEP      = cnt_t'(COORD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_X,
    ST_RUN_X,
    ST_LOAD_Y,
    ST_RUN_Y,
    ST_PUSH
  } mrc_state_t;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic   done;
    coord_t quot;
  } div_res_t;

endpackage

// ----- design/mrc_if.sv -----
// mrc_in_if and mrc_out_if: valid/ready channels carrying one region word in
// and one centroid word out. depends on mrc_pkg.

interface mrc_in_if;
  logic                 valid;
  logic                 ready;
  mrc_pkg::sum_in_t     region_sum_x;
  mrc_pkg::sum_in_t     region_sum_y;
  mrc_pkg::weight_in_t  region_weight;
  logic                 end_of_star;

  modport source (output valid, region_sum_x, region_sum_y, region_weight, end_of_star,
                  input ready);
  modport sink   (input valid, region_sum_x, region_sum_y, region_weight, end_of_star,
                  output ready);
endinterface

interface mrc_out_if;
  logic                 valid;
  logic                 ready;
  mrc_pkg::coord_out_t  centroid_x;
  mrc_pkg::coord_out_t  centroid_y;
  logic                 zero_weight;

  modport source (output valid, centroid_x, centroid_y, zero_weight, input ready);
  modport sink   (input valid, centroid_x, centroid_y, zero_weight, output ready);
endinterface

// ----- design/mrc_accum.sv -----
// mrc_accum: saturating running totals of x sum, y sum and weight.
// depends on mrc_pkg.

module mrc_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrc_pkg::acc_ctrl_t   ctrl,
  input  mrc_pkg::sum_in_t     sum_x,
  input  mrc_pkg::sum_in_t     sum_y,
  input  mrc_pkg::weight_in_t  weight,
  output mrc_pkg::total_sum_t  tot_x,
  output mrc_pkg::total_sum_t  tot_y,
  output mrc_pkg::total_w_t    tot_w
);

  mrc_pkg::total_sum_t tot_x_r, tot_x_nxt;
  mrc_pkg::total_sum_t tot_y_r, tot_y_nxt;
  mrc_pkg::total_w_t   tot_w_r, tot_w_nxt;
  mrc_pkg::sum_ext_t   add_x, add_y;
  mrc_pkg::w_ext_t     add_w;
  mrc_pkg::total_w_t   w_masked;

  always_comb begin
    w_masked = mrc_pkg::total_w_t'(weight) & mrc_pkg::WEIGHT_IN_MASK;
    add_x = {1'b0, tot_x_r} + mrc_pkg::sum_ext_t'(sum_x);
    add_y = {1'b0, tot_y_r} + mrc_pkg::sum_ext_t'(sum_y);
    add_w = {1'b0, tot_w_r} + mrc_pkg::w_ext_t'(w_masked);
    tot_x_nxt = tot_x_r;
    tot_y_nxt = tot_y_r;
    tot_w_nxt = tot_w_r;
    if (ctrl.clear) begin
      tot_x_nxt = '0;
      tot_y_nxt = '0;
      tot_w_nxt = '0;
    end else if (ctrl.add) begin
      tot_x_nxt = add_x[mrc_pkg::TOTAL_SUM_W] ? mrc_pkg::TOTAL_SUM_MAX
                                             : add_x[mrc_pkg::TOTAL_SUM_W-1:0];
      tot_y_nxt = add_y[mrc_pkg::TOTAL_SUM_W] ? mrc_pkg::TOTAL_SUM_MAX
                                             : add_y[mrc_pkg::TOTAL_SUM_W-1:0];
      tot_w_nxt = add_w[mrc_pkg::TOTAL_W_W] ? mrc_pkg::TOTAL_W_MAX
                                           : add_w[mrc_pkg::TOTAL_W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_x_r <= '0;
      tot_y_r <= '0;
      tot_w_r <= '0;
    end else begin
      tot_x_r <= tot_x_nxt;
      tot_y_r <= tot_y_nxt;
      tot_w_r <= tot_w_nxt;
    end
  end

  assign tot_x = tot_x_r;
  assign tot_y = tot_y_r;
  assign tot_w = tot_w_r;

endmodule

// ----- design/mrc_div.sv -----
// mrc_div: restoring divider, one quotient bit per cycle, with a first step
// that detects a quotient above the coordinate range. depends on mrc_pkg.

module mrc_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mrc_pkg::total_sum_t  dividend,
  input  mrc_pkg::total_w_t    divisor,
  output mrc_pkg::div_res_t    res
);

  mrc_pkg::div_t   rem_r, rem_nxt;
  mrc_pkg::div_t   dsr_r, dsr_nxt;
  mrc_pkg::coord_t q_r, q_nxt;
  mrc_pkg::cnt_t   cnt_r, cnt_nxt;
  logic            sat_r, sat_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            ge;

  always_comb begin
    ge       = (rem_r >= dsr_r);
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = mrc_pkg::div_t'(dividend);
      dsr_nxt  = mrc_pkg::div_t'(divisor) << mrc_pkg::COORD_BITS;
      q_nxt    = '0;
      cnt_nxt  = '0;
      sat_nxt  = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dsr_nxt = dsr_r >> 1;
      if (cnt_r == '0) begin
        // quotient would not fit the coordinate range
        sat_nxt = ge;
      end else begin
        if (ge) begin
          rem_nxt = rem_r - dsr_r;
        end
        q_nxt = {q_r[mrc_pkg::COORD_BITS-2:0], ge};
      end
      if (cnt_r == mrc_pkg::LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + mrc_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
  end

  assign res.done = done_r;
  assign res.quot = sat_r ? '1 : q_r;

endmodule

// ----- design/merged_region_centroid.sv -----
// merged_region_centroid: top level, sequencer and output register around
// the running totals and the shared serial divider.
// depends on mrc_pkg, mrc_if, mrc_accum and mrc_div.
//
//   channel   dir   carries                                       handshake
//   in_chan   in    region_sum_x, region_sum_y, region_weight,    valid/ready
//                   end_of_star
//   out_chan  out   centroid_x, centroid_y, zero_weight           valid/ready
//
// a region word without end_of_star is taken every cycle while the sequencer
// is idle. a word with end_of_star runs the one-bit-a-cycle divider once for x
// and once for y; no word is taken until the result is pushed.
// zero total weight skips the divider.
// rst_n clears the totals, the sequencer and the output valid flag.
// a stalled result holds in the output register; the next star's regions are
// still accepted, but once its result is ready no word is taken until it moves.

module merged_region_centroid (
  input logic        clk,
  input logic        rst_n,
  mrc_in_if.sink     in_chan,
  mrc_out_if.source  out_chan
);

  mrc_pkg::mrc_state_t  state_r, state_nxt;
  mrc_pkg::acc_ctrl_t   acc_ctrl;
  mrc_pkg::div_res_t    div_res;
  mrc_pkg::total_sum_t  acc_tx, acc_ty;
  mrc_pkg::total_w_t    acc_tw;
  logic                 div_start, div_sel_y;
  logic                 push_ok;
  mrc_pkg::coord_t      cx_r, cx_nxt;
  logic                 zw_r, zw_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mrc_pkg::coord_t      ox_r, ox_nxt, oy_r, oy_nxt;
  logic                 ozw_r, ozw_nxt;

  mrc_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (acc_ctrl),
    .sum_x  (in_chan.region_sum_x),
    .sum_y  (in_chan.region_sum_y),
    .weight (in_chan.region_weight),
    .tot_x  (acc_tx),
    .tot_y  (acc_ty),
    .tot_w  (acc_tw)
  );

  mrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_sel_y ? acc_ty : acc_tx),
    .divisor  (acc_tw),
    .res      (div_res)
  );

  assign push_ok = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    acc_ctrl       = '0;
    div_start      = 1'b0;
    div_sel_y      = 1'b0;
    cx_nxt         = cx_r;
    zw_nxt         = zw_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    ozw_nxt        = ozw_r;
    case (state_r)
      mrc_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          acc_ctrl.add = 1'b1;
          if (in_chan.end_of_star) begin
            state_nxt = mrc_pkg::ST_LOAD_X;
          end
        end
      end
      mrc_pkg::ST_LOAD_X: begin
        if (acc_tw == '0) begin
          zw_nxt    = 1'b1;
          cx_nxt    = '0;
          state_nxt = mrc_pkg::ST_PUSH;
        end else begin
          zw_nxt    = 1'b0;
          div_start = 1'b1;
          state_nxt = mrc_pkg::ST_RUN_X;
        end
      end
      mrc_pkg::ST_RUN_X: begin
        if (div_res.done) begin
          cx_nxt    = div_res.quot;
          state_nxt = mrc_pkg::ST_LOAD_Y;
        end
      end
      mrc_pkg::ST_LOAD_Y: begin
        div_start = 1'b1;
        div_sel_y = 1'b1;
        state_nxt = mrc_pkg::ST_RUN_Y;
      end
      mrc_pkg::ST_RUN_Y: begin
        if (div_res.done) begin
          state_nxt = mrc_pkg::ST_PUSH;
        end
      end
      mrc_pkg::ST_PUSH: begin
        if (push_ok) begin
          out_valid_nxt  = 1'b1;
          ox_nxt         = cx_r;
          oy_nxt         = zw_r ? '0 : div_res.quot;
          ozw_nxt        = zw_r;
          acc_ctrl.clear = 1'b1;
          state_nxt      = mrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r  <= cx_nxt;
    zw_r  <= zw_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
    ozw_r <= ozw_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.centroid_x  = mrc_pkg::coord_out_t'(ox_r);
  assign out_chan.centroid_y  = mrc_pkg::coord_out_t'(oy_r);
  assign out_chan.zero_weight = ozw_r;

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == mrc_pkg::ST_RUN_X || state_r == mrc_pkg::ST_RUN_Y))
    else $error("divider finished outside a divide phase");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ozw_r) |-> (ox_r == '0 && oy_r == '0))
    else $error("zero weight word with non-zero coordinates");

  a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrc_pkg::ST_PUSH && push_ok) |=> (acc_tw == '0 && out_valid_r))
    else $error("totals not cleared or word lost after push");

  a_no_start_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (acc_tw != '0))
    else $error("divide started with zero weight");

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for merged_region_centroid. sends region words,
// predicts each star centroid from running totals and checks every result word.
// depends on mrc_pkg and the channel interfaces in mrc_if.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int STAR_LATENCY = 2 * (mrc_pkg::COORD_BITS + 3) + 2;
  localparam int DRAIN_CYCLES = 4 * STAR_LATENCY;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 180;
  localparam int OVERFLOW_REGIONS = 260;
  localparam longint CYCLE_LIMIT = 400000;

  localparam logic [63:0] SUM_IN_MAX = (64'd1 << mrc_pkg::SUM_IN_W) - 1;
  localparam logic [63:0] WEIGHT_IN_MAX = (64'd1 << mrc_pkg::WEIGHT_IN_W) - 1;
  localparam logic [63:0] WEIGHT_USED_MASK = (64'd1 << mrc_pkg::WEIGHT_BITS) - 1;
  localparam logic [63:0] SUM_TOTAL_MAX = (64'd1 << mrc_pkg::TOTAL_SUM_W) - 1;
  localparam logic [63:0] WEIGHT_TOTAL_MAX = (64'd1 << mrc_pkg::TOTAL_W_W) - 1;
  localparam logic [63:0] COORD_MAX = (64'd1 << mrc_pkg::COORD_BITS) - 1;

  typedef struct packed {
    mrc_pkg::coord_out_t cx;
    mrc_pkg::coord_out_t cy;
    logic                zw;
  } centroid_t;

  logic clk = 1'b0;
  logic rst_n;

  mrc_in_if  in_chan();
  mrc_out_if out_chan();

  merged_region_centroid u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // running star totals and the centroids still owed by the block
  logic [63:0] acc_x = '0;
  logic [63:0] acc_y = '0;
  logic [63:0] acc_w = '0;
  centroid_t   centroid_q[$];

  int     fail_cnt = 0;
  int     words_sent = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  longint cycle_cnt = 0;

  function automatic logic [63:0] add_clamped(logic [63:0] acc, logic [63:0] add,
                                              logic [63:0] top);
    logic [63:0] s;
    s = acc + add;
    return (s > top) ? top : s;
  endfunction

  function automatic void accumulate_region(logic [63:0] sx, logic [63:0] sy,
                                            logic [63:0] w, logic eos);
    centroid_t   c;
    logic [63:0] qx;
    logic [63:0] qy;
    acc_x = add_clamped(acc_x, sx, SUM_TOTAL_MAX);
    acc_y = add_clamped(acc_y, sy, SUM_TOTAL_MAX);
    acc_w = add_clamped(acc_w, w & WEIGHT_USED_MASK, WEIGHT_TOTAL_MAX);
    if (eos) begin
      if (acc_w == 0) begin
        c = '{cx: '0, cy: '0, zw: 1'b1};
      end else begin
        qx = acc_x / acc_w;
        qy = acc_y / acc_w;
        c.cx = mrc_pkg::coord_out_t'((qx > COORD_MAX) ? COORD_MAX : qx);
        c.cy = mrc_pkg::coord_out_t'((qy > COORD_MAX) ? COORD_MAX : qy);
        c.zw = 1'b0;
      end
      centroid_q.push_back(c);
      acc_x = '0;
      acc_y = '0;
      acc_w = '0;
    end
  endfunction

  task automatic send_region(input logic [63:0] sx, input logic [63:0] sy,
                             input logic [63:0] w, input logic eos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.region_sum_x  <= mrc_pkg::sum_in_t'(sx);
    in_chan.region_sum_y  <= mrc_pkg::sum_in_t'(sy);
    in_chan.region_weight <= mrc_pkg::weight_in_t'(w);
    in_chan.end_of_star   <= eos;
    do @(posedge clk); while (!in_chan.ready);
    accumulate_region(sx & SUM_IN_MAX, sy & SUM_IN_MAX, w & WEIGHT_IN_MAX, eos);
    words_sent++;
  endtask

  task automatic send_random_star();
    int          n;
    int          kind;
    int          cx;
    int          cy;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] w;
    n    = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    kind = $urandom_range(99);
    cx   = $urandom_range(0, 1100);
    cy   = $urandom_range(0, 1100);
    for (int i = 0; i < n; i++) begin
      if (kind < 60) begin
        // plausible star: sums near coordinate times weight
        w  = 64'($urandom) >> $urandom_range(0, 31);
        sx = 64'(cx) * w + ((w == 0) ? 64'd0 : 64'($urandom) % w);
        sy = 64'(cy) * w + ((w == 0) ? 64'd0 : 64'($urandom) % w);
        if (sx > SUM_IN_MAX) sx = SUM_IN_MAX;
        if (sy > SUM_IN_MAX) sy = SUM_IN_MAX;
      end else if (kind < 75) begin
        w  = 64'($urandom) >> $urandom_range(0, 8);
        sx = ({$urandom, $urandom} >> $urandom_range(0, 40)) & SUM_IN_MAX;
        sy = ({$urandom, $urandom} >> $urandom_range(0, 40)) & SUM_IN_MAX;
      end else if (kind < 85) begin
        w  = 64'd0;
        sx = ({$urandom, $urandom} >> $urandom_range(0, 41)) & SUM_IN_MAX;
        sy = ({$urandom, $urandom} >> $urandom_range(0, 41)) & SUM_IN_MAX;
      end else begin
        w  = $urandom_range(0, 15);
        sx = $urandom_range(0, 20000);
        sy = $urandom_range(0, 20000);
      end
      send_region(sx, sy, w, i == n - 1);
    end
  endtask

  // single-region stars: zero weight, truncation, saturation, bit patterns
  task automatic test_lone_regions();
    send_region(SUM_IN_MAX, SUM_IN_MAX, 64'd0, 1'b1);
    send_region(64'd0, 64'd0, 64'd0, 1'b1);
    send_region(SUM_IN_MAX, SUM_IN_MAX, 64'd1, 1'b1);
    send_region(64'd1023 * 1000, 64'd0, 64'd1000, 1'b1);
    send_region(64'd1024 * 1000, 64'd1024 * 1000 - 1, 64'd1000, 1'b1);
    send_region(64'd512 * WEIGHT_IN_MAX + WEIGHT_IN_MAX - 1, WEIGHT_IN_MAX - 1,
                WEIGHT_IN_MAX, 1'b1);
    send_region(64'd22, 64'd6, 64'd7, 1'b1);
    send_region(64'h2AA_AAAA_AAAA, 64'h155_5555_5555, 64'hAAAA_AAAA, 1'b1);
    send_region(64'h155_5555_5555, 64'h2AA_AAAA_AAAA, 64'h5555_5555, 1'b1);
  endtask

  // stars merged from several regions, zero weight in various places
  task automatic test_merged_regions();
    send_region(64'd100 * 50, 64'd200 * 50, 64'd50, 1'b0);
    send_region(64'd300 * 150, 64'd10 * 150, 64'd150, 1'b0);
    send_region(64'd700 * 3, 64'd999 * 3, 64'd3, 1'b1);
    send_region(64'd5000, 64'd7000, 64'd0, 1'b0);
    send_region(64'd40 * 20, 64'd60 * 20, 64'd20, 1'b1);
    send_region(64'd40 * 20, 64'd60 * 20, 64'd20, 1'b0);
    send_region(64'd9000, 64'd12345, 64'd0, 1'b1);
    send_region(64'd77, 64'd0, 64'd0, 1'b0);
    send_region(64'd0, 64'd88, 64'd0, 1'b1);
  endtask

  // enough full-scale regions that every running total clamps
  task automatic test_total_overflow();
    for (int i = 0; i <= OVERFLOW_REGIONS; i++)
      send_region(SUM_IN_MAX, SUM_IN_MAX, WEIGHT_IN_MAX, i == OVERFLOW_REGIONS);
  endtask

  // result side stalls for a long stretch while words keep coming
  task automatic test_back_pressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 15; i++)
      send_random_star();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_words);
    int target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = words_sent + n_words;
    while (words_sent < target)
      send_random_star();
  endtask

  // result side: ready pattern and comparison against the oldest centroid owed
  always @(posedge clk) begin : result_side
    centroid_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (centroid_q.size() == 0) begin
          fail_cnt++;
          $error("centroid word with no star pending");
        end else begin
          want = centroid_q.pop_front();
          if (out_chan.centroid_x !== want.cx) begin
            fail_cnt++;
            $error("centroid_x expected %0d actual %0d", want.cx, out_chan.centroid_x);
          end
          if (out_chan.centroid_y !== want.cy) begin
            fail_cnt++;
            $error("centroid_y expected %0d actual %0d", want.cy, out_chan.centroid_y);
          end
          if (out_chan.zero_weight !== want.zw) begin
            fail_cnt++;
            $error("zero_weight expected %0b actual %0b", want.zw, out_chan.zero_weight);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen      <= hold_req;
        hold_left      <= HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left      <= hold_left - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.region_sum_x  <= '0;
    in_chan.region_sum_y  <= '0;
    in_chan.region_weight <= '0;
    in_chan.end_of_star   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 71;
    test_lone_regions();
    test_merged_regions();
    test_total_overflow();
    test_back_pressure();
    test_random_traffic(25, 71, PHASE_WORDS);
    test_random_traffic(71, 25, PHASE_WORDS);
    test_random_traffic(0, 0, PHASE_WORDS);

    in_chan.valid <= 1'b0;
    while (centroid_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
